// ===== sv/sine_cosine_taylor_defines.svh =====
// Assertion macros for the sine/cosine Taylor block.
// Assertions compile to nothing when SYNTHESIS is defined.
`ifndef SINE_COSINE_TAYLOR_DEFINES_SVH
`define SINE_COSINE_TAYLOR_DEFINES_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define SCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Condition in one cycle implies consequence in the next
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SCT_ASSERT(label, prop, msg)
`define SCT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/sct_pkg.sv =====
// Shared constants and the cell-to-cell bus type for the sine/cosine block.
// No dependencies.
package sct_pkg;

    // Q52 angle constants, rounded to nearest
    localparam logic [59:0] TWO_PI_Q52  = 60'h6487ED5110B461;
    localparam logic [59:0] PI_Q52      = 60'h3243F6A8885A31;
    localparam logic [59:0] HALF_PI_Q52 = 60'h1921FB54442D18;

    // Plus one in Q30
    localparam logic [30:0] ONE_Q30 = 31'h40000000;

    // Beat handed from one series cell to the next
    typedef struct packed {
        logic               valid;
        logic               tsign;
        logic [59:0]        tmag;
        logic [59:0]        x2;
        logic signed [63:0] sum;
    } t_cell_bus;

endpackage

// ===== sv/sct_mul.sv =====
// Pipelined 60x60 magnitude multiplier, rounded to Q56, plus a constant.
// Three register stages. No dependencies.
module sct_mul #(
    parameter int RND = 0
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [59:0] i_a,
    input  logic [59:0] i_b,
    output logic [62:0] o_p
);

    // Round to nearest at bit 55, and add RND in the result scale
    localparam logic [120:0] ADD = (121'(RND) << 56) | (121'(1) << 55);

    logic [59:0]  r_ll;
    logic [59:0]  r_lh;
    logic [59:0]  r_hl;
    logic [59:0]  r_hh;
    logic [60:0]  r_mid;
    logic [59:0]  r_ll2;
    logic [59:0]  r_hh2;
    logic [62:0]  r_p;
    logic [120:0] n_sum;

    // Combine partial products into the rounded result
    always_comb begin
        n_sum = 121'(r_ll2) + (121'(r_mid) << 30) + (121'(r_hh2) << 60) + ADD;
    end

    // Advance partial products, middle sum and result
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= 60'(i_a[29:0])  * 60'(i_b[29:0]);
            r_lh  <= 60'(i_a[29:0])  * 60'(i_b[59:30]);
            r_hl  <= 60'(i_a[59:30]) * 60'(i_b[29:0]);
            r_hh  <= 60'(i_a[59:30]) * 60'(i_b[59:30]);
            r_mid <= 61'(r_lh) + 61'(r_hl);
            r_ll2 <= r_ll;
            r_hh2 <= r_hh;
            r_p   <= n_sum[118:56];
        end
    end

    assign o_p = r_p;

endmodule

// ===== sv/sct_reduce.sv =====
// Angle widening, optional quarter-turn offset, reduction modulo 2*pi
// and fold into [-pi, pi]. Eight stages. Depends on sct_pkg.
module sct_reduce (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_mode,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    output logic               o_xsign,
    output logic [57:0]        o_xmag
);
    import sct_pkg::*;

    logic [7:0]         r_vld;
    logic signed [60:0] r_x52;
    logic [59:0]        r_m [0:5];
    logic               r_sg [0:5];
    logic               r_xs;
    logic [57:0]        r_xm;
    logic signed [60:0] n_x52;
    logic [59:0]        n_fold;

    // Widen to Q52 and add the quarter turn for cosine
    always_comb begin
        n_x52 = (61'(i_angle) <<< 28) + signed'(61'(i_mode ? HALF_PI_Q52 : 60'd0));
        n_fold = (r_m[5] > PI_Q52) ? (TWO_PI_Q52 - r_m[5]) : r_m[5];
    end

    // Track beats through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    // Split sign and magnitude, subtract 16T..T, then fold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x52   <= n_x52;
            r_sg[0] <= r_x52[60];
            r_m[0]  <= r_x52[60] ? 60'(-r_x52) : 60'(r_x52);
            for (int j = 0; j < 5; j++) begin
                r_sg[j+1] <= r_sg[j];
                if (r_m[j] >= (TWO_PI_Q52 << (4 - j))) begin
                    r_m[j+1] <= r_m[j] - (TWO_PI_Q52 << (4 - j));
                end else begin
                    r_m[j+1] <= r_m[j];
                end
            end
            r_xs <= (r_m[5] > PI_Q52) ? !r_sg[5] : r_sg[5];
            r_xm <= {n_fold[53:0], 4'b0000};
        end
    end

    assign o_valid = r_vld[7];
    assign o_xsign = r_xs;
    assign o_xmag  = r_xm;

endmodule

// ===== sv/sct_cell.sv =====
// One series cell: next term = -term * x^2 / K, rounded, and accumulate.
// Nine stages. Depends on sct_pkg and sct_mul.
module sct_cell #(
    parameter int K = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  sct_pkg::t_cell_bus i_bus,
    output sct_pkg::t_cell_bus o_bus
);
    import sct_pkg::*;

    // Exact reciprocal for 32-bit dividends
    localparam int          L   = $clog2(K);
    localparam int          S   = 32 + L;
    localparam logic [33:0] MUL = 34'(((64'd1 << S) + 64'(K) - 64'd1) / 64'(K));

    logic [62:0] w_n;
    t_cell_bus   r_dly [0:7];
    t_cell_bus   r_out;
    t_cell_bus   n_out;
    logic [31:0] r_v0;
    logic [65:0] r_pr0;
    logic [41:0] r_lo4;
    logic [20:0] r_q0_5;
    logic [31:0] r_v1;
    logic [20:0] r_d2_5;
    logic [65:0] r_pr1;
    logic [31:0] r_v1_6;
    logic [20:0] r_q0_6;
    logic [20:0] r_d2_6;
    logic [20:0] r_q0_7;
    logic [20:0] r_q1_7;
    logic [31:0] r_v2;
    logic [65:0] r_pr2;
    logic [20:0] r_q0_8;
    logic [20:0] r_q1_8;
    logic [20:0] w_q0;
    logic [20:0] w_q1;
    logic [20:0] w_q2;
    logic [31:0] w_rem0;
    logic [31:0] w_rem1;
    logic [62:0] w_q;
    logic [63:0] w_term;

    // Rounded product plus K/2, ready for division by K
    sct_mul #(.RND(K / 2)) u_mul (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_bus.tmag),
        .i_b   (i_bus.x2),
        .o_p   (w_n)
    );

    // Quotient digits and remainders
    always_comb begin
        w_q0   = r_pr0[S +: 21];
        w_rem0 = r_v0 - 32'(w_q0) * 32'(K);
        w_q1   = r_pr1[S +: 21];
        w_rem1 = r_v1_6 - 32'(w_q1) * 32'(K);
        w_q2   = r_pr2[S +: 21];
        w_q    = {r_q0_8, r_q1_8, w_q2};
        n_out       = r_dly[7];
        n_out.tsign = !r_dly[7].tsign;
        n_out.tmag  = w_q[59:0];
        w_term      = n_out.tsign ? -64'(w_q[59:0]) : 64'(w_q[59:0]);
        n_out.sum   = r_dly[7].sum + signed'(w_term);
    end

    // Carry the beat alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 8; j++) begin
                r_dly[j].valid <= 1'b0;
            end
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_dly[0] <= i_bus;
            for (int j = 1; j < 8; j++) begin
                r_dly[j] <= r_dly[j-1];
            end
            r_out <= n_out;
        end
    end

    // Divide by K one 21-bit digit at a time
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0   <= 32'(w_n[62:42]);
            r_pr0  <= 66'(w_n[62:42]) * 66'(MUL);
            r_lo4  <= w_n[41:0];
            r_q0_5 <= w_q0;
            r_v1   <= (w_rem0 << 21) | 32'(r_lo4[41:21]);
            r_d2_5 <= r_lo4[20:0];
            r_pr1  <= 66'(r_v1) * 66'(MUL);
            r_v1_6 <= r_v1;
            r_q0_6 <= r_q0_5;
            r_d2_6 <= r_d2_5;
            r_q0_7 <= r_q0_6;
            r_q1_7 <= w_q1;
            r_v2   <= (w_rem1 << 21) | 32'(r_d2_6);
            r_pr2  <= 66'(r_v2) * 66'(MUL);
            r_q0_8 <= r_q0_7;
            r_q1_8 <= r_q1_7;
        end
    end

    assign o_bus = r_out;

endmodule

// ===== sv/sine_cosine_taylor.sv =====
// Sine or cosine of a Q24 radian angle by a Taylor series; Q30 result.
// Input channel: i_valid, o_stall, i_mode (0 sine, 1 cosine), i_angle.
// Output channel: o_valid, i_stall, o_value, saturated to +-1.0.
// A beat moves when valid is high and stall is low.
// Throughput: one beat per cycle, sustained, while results are taken.
// The path from an input beat to output valid runs through the eight-stage
// angle reduction, the three-stage squaring multiplier, nine stages per
// series cell and two rounding stages ahead of a two-entry output buffer.
// The whole pipeline advances together; it freezes only when the output
// buffer holds two results, so one new beat is still taken while a
// finished result waits. o_stall is high exactly while frozen.
// Reset (synchronous, active low) empties the pipeline and the buffer.
// Depends on sct_pkg, sct_reduce, sct_mul, sct_cell and the defines header.
`include "sine_cosine_taylor_defines.svh"
module sine_cosine_taylor #(
    parameter int TERM_COUNT = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_angle,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value
);
    import sct_pkg::*;

    logic        w_en;
    logic        w_xv;
    logic        w_xs;
    logic [57:0] w_xm;
    logic [62:0] w_sq;
    logic [2:0]  r_sq_vld;
    logic        r_sq_s [0:2];
    logic [57:0] r_sq_m [0:2];
    t_cell_bus   w_bus [0:TERM_COUNT];
    logic        r_o1_vld;
    logic        r_o1_s;
    logic [63:0] r_o1_m;
    logic        r_o2_vld;
    logic        r_o2_s;
    logic [30:0] r_o2_m;
    logic [63:0] n_rnd;
    logic [31:0] n_val;
    logic [31:0] r_buf [0:1];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic        w_pop;

    // Advance unless the output buffer is full
    assign w_en    = (r_cnt != 2'd2);
    assign o_stall = !w_en;

    sct_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .i_angle (i_angle),
        .o_valid (w_xv),
        .o_xsign (w_xs),
        .o_xmag  (w_xm)
    );

    // Square the reduced angle
    sct_mul #(.RND(0)) u_sq (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (60'(w_xm)),
        .i_b   (60'(w_xm)),
        .o_p   (w_sq)
    );

    // Hold x beside the squaring stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
        end else if (w_en) begin
            r_sq_vld <= {r_sq_vld[1:0], w_xv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_s[0] <= w_xs;
            r_sq_m[0] <= w_xm;
            for (int j = 1; j < 3; j++) begin
                r_sq_s[j] <= r_sq_s[j-1];
                r_sq_m[j] <= r_sq_m[j-1];
            end
        end
    end

    // First term and running sum are x itself
    always_comb begin
        w_bus[0].valid = r_sq_vld[2];
        w_bus[0].tsign = r_sq_s[2];
        w_bus[0].tmag  = 60'(r_sq_m[2]);
        w_bus[0].x2    = w_sq[59:0];
        w_bus[0].sum   = r_sq_s[2] ? -signed'(64'(r_sq_m[2])) : signed'(64'(r_sq_m[2]));
    end

    // Chain of series cells, K = 2i(2i+1)
    for (genvar g = 0; g < TERM_COUNT; g++) begin : g_cell
        localparam int KI = (2 * (g + 1)) * (2 * (g + 1) + 1);
        sct_cell #(.K(KI)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    // Round Q56 magnitude to Q30 and saturate
    always_comb begin
        n_rnd = r_o1_m + (64'd1 << 25);
        n_val = r_o2_s ? -32'(r_o2_m) : 32'(r_o2_m);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_vld <= 1'b0;
            r_o2_vld <= 1'b0;
        end else if (w_en) begin
            r_o1_vld <= w_bus[TERM_COUNT].valid;
            r_o2_vld <= r_o1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o1_s <= w_bus[TERM_COUNT].sum[63];
            r_o1_m <= w_bus[TERM_COUNT].sum[63] ? 64'(-w_bus[TERM_COUNT].sum)
                                                : 64'(w_bus[TERM_COUNT].sum);
            r_o2_s <= r_o1_s;
            r_o2_m <= (n_rnd[63:26] > 38'(ONE_Q30)) ? ONE_Q30 : n_rnd[56:26];
        end
    end

    // Two-entry output buffer
    assign w_push = w_en && r_o2_vld;
    assign w_pop  = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (w_push) begin
                r_buf[r_wr] <= n_val;
                r_wr        <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= 2'(r_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_value = signed'(r_buf[r_rd]);

    `SCT_ASSERT(a_cnt_range, r_cnt != 2'd3, "output buffer count out of range")
    `SCT_ASSERT(a_no_push_full, !(w_push && r_cnt == 2'd2), "push into full output buffer")
    `SCT_ASSERT_NEXT(a_empty_idle, r_cnt == 2'd0 && !w_push, !o_valid, "result from nowhere")
    `SCT_ASSERT_NEXT(a_pop_shrinks, w_pop && !w_push, r_cnt == $past(r_cnt) - 2'd1, "pop lost")

endmodule
